// File: sv/mcds_pkg.sv
// shared constants and types for the multiplexed counter delta scaler
// no dependencies; imported by mcds_mdu and the core top level
package mcds_pkg;

    localparam int COUNTER_SLOTS = 8;
    localparam int SLOT_W        = 3;
    localparam int CNT_W         = 64;
    localparam int PROD_W        = 2 * CNT_W;
    localparam int CFG_W         = 8;
    localparam int CAP_W         = CNT_W + CFG_W;
    localparam int IN_TDATA_W    = ((SLOT_W + 3 * CNT_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W   = ((SLOT_W + CNT_W + 7) / 8) * 8;
    localparam int STEP_W        = $clog2(CNT_W);

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

    typedef enum logic {
        MDU_MUL,
        MDU_DIV
    } t_mdu_op;

    typedef struct packed {
        logic    go;
        t_mdu_op op;
    } t_mdu_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mdu_stat;

endpackage

// File: sv/mcds_mdu.sv
// bit-serial multiply / divide unit sharing one 66-bit add-subtract path
// depends on mcds_pkg; multiply leaves a 128-bit product in hi:lo, divide
// takes hi:lo as dividend (hi below divisor) and leaves the quotient in lo
module mcds_mdu
    import mcds_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_mdu_cmd            i_cmd,
    input  logic [CNT_W-1:0]    i_opa,
    input  logic [CNT_W-1:0]    i_opb,
    output t_mdu_stat           o_stat,
    output logic [CNT_W-1:0]    o_hi,
    output logic [CNT_W-1:0]    o_lo
);

    logic [CNT_W-1:0]  r_hi;
    logic [CNT_W-1:0]  r_lo;
    logic [CNT_W-1:0]  r_d;
    logic [STEP_W-1:0] r_step;
    t_mdu_op           r_op;
    logic              r_busy;
    logic              r_done;

    logic [CNT_W+1:0]  add_a;
    logic [CNT_W+1:0]  add_b;
    logic [CNT_W+1:0]  add_y;
    logic              ge;

    // multiply adds the multiplicand to hi, divide trials divisor against hi:next bit
    always_comb begin
        if (r_op == MDU_MUL) begin
            add_a = {2'b00, r_hi};
        end else begin
            add_a = {1'b0, r_hi, r_lo[CNT_W-1]};
        end
        add_b = {2'b00, r_d};
        add_y = (r_op == MDU_MUL) ? (add_a + add_b) : (add_a - add_b);
        ge    = ~add_y[CNT_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= MDU_MUL;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.go) begin
                r_busy <= 1'b1;
                r_op   <= i_cmd.op;
                r_step <= '1;
                r_d    <= i_opa;
                if (i_cmd.op == MDU_MUL) begin
                    r_hi <= '0;
                    r_lo <= i_opb;
                end
            end else if (r_busy) begin
                if (r_op == MDU_MUL) begin
                    if (r_lo[0]) begin
                        r_hi <= add_y[CNT_W:1];
                        r_lo <= {add_y[0], r_lo[CNT_W-1:1]};
                    end else begin
                        r_hi <= {1'b0, r_hi[CNT_W-1:1]};
                        r_lo <= {r_hi[0], r_lo[CNT_W-1:1]};
                    end
                end else begin
                    if (ge) begin
                        r_hi <= add_y[CNT_W-1:0];
                    end else begin
                        r_hi <= {r_hi[CNT_W-2:0], r_lo[CNT_W-1]};
                    end
                    r_lo <= {r_lo[CNT_W-2:0], ge};
                end
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_hi        = r_hi;
    assign o_lo        = r_lo;

endmodule

// File: sv/multiplexed_counter_delta_scaler_core.sv
// top level of the multiplexed counter delta scaler: per-slot history,
// delta sequencer, scale cap and output register; depends on mcds_pkg, mcds_mdu
//
// channel   dir  transaction contents
// s_axis    in   one counter reading: slot, read_failed, raw_count, enabled, running
// m_axis    out  one result per reading: out_slot, scaled_delta
// cfg       in   write of max_scale_factor (8 bits)
//
// an unscaled reading runs S_DCNT, S_DEN, S_DRUN, S_CHK, S_DONE; a failed one just S_DONE
// a scaled reading also runs 64 steps of the serial multiplier and, unless the quotient
// saturates, 64 steps of the serial divider, both in the one shared unit
// i_rst_n is synchronous; it clears the slot history, sets the factor to 8
// the input side is ready only in idle; a stalled output holds its register
// and the next reading may already be accepted behind it
module multiplexed_counter_delta_scaler_core
    import mcds_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave side
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // [2:0] slot, [66:3] raw_count, [130:67] time_enabled,
    // [194:131] time_running, rest zero
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // [0] read_failed
    input  logic                   i_s_tuser,
    // master side
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // [2:0] out_slot, [66:3] scaled_delta, rest zero
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // configuration write
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DCNT,
        S_DEN,
        S_DRUN,
        S_CHK,
        S_CAP,
        S_CLIP,
        S_MUL,
        S_SAT,
        S_DIV,
        S_DONE
    } t_state;

    t_state             r_state;

    // captured reading
    logic [SLOT_W-1:0]  r_slot;
    logic               r_skip;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_en;
    logic [CNT_W-1:0]   r_run;

    // working values
    logic [CNT_W-1:0]   r_dcnt;
    logic [CNT_W-1:0]   r_den;
    logic [CNT_W-1:0]   r_drun;
    logic [CAP_W-1:0]   r_cap;
    logic [CNT_W-1:0]   r_res;

    // per-slot history
    logic [CNT_W-1:0]   r_last_cnt [COUNTER_SLOTS];
    logic [CNT_W-1:0]   r_last_en  [COUNTER_SLOTS];
    logic [CNT_W-1:0]   r_last_run [COUNTER_SLOTS];

    logic [CFG_W-1:0]   r_cfg;

    // output register
    logic               r_out_valid;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [CNT_W-1:0]   r_out_res;

    // shared delta subtractor and helpers
    logic [CNT_W-1:0]   sub_a;
    logic [CNT_W-1:0]   sub_b;
    logic [CNT_W-1:0]   sub_y;
    logic [CFG_W-1:0]   factor;
    logic [CNT_W-1:0]   den_clip;
    logic               slot_ok;
    logic               in_acc;
    logic               sat;

    t_mdu_cmd           mdu_cmd;
    t_mdu_stat          mdu_stat;
    logic [CNT_W-1:0]   mdu_opa;
    logic [CNT_W-1:0]   mdu_hi;
    logic [CNT_W-1:0]   mdu_lo;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_s_tvalid && o_s_tready;
    assign slot_ok     = (int'(i_s_tdata[SLOT_W-1:0]) < COUNTER_SLOTS);

    // a zero factor behaves as one, i.e. no scale-up
    assign factor = (r_cfg == '0) ? CFG_W'(1) : r_cfg;

    // one subtractor walks the three deltas
    always_comb begin
        case (r_state)
            S_DCNT: begin
                sub_a = r_cnt;
                sub_b = r_last_cnt[r_slot];
            end
            S_DEN: begin
                sub_a = r_en;
                sub_b = r_last_en[r_slot];
            end
            default: begin
                sub_a = r_run;
                sub_b = r_last_run[r_slot];
            end
        endcase
        sub_y = sub_a - sub_b;
    end

    // enabled delta capped at running delta times the factor, when that fits
    assign den_clip = ((r_cap[CAP_W-1:CNT_W] == '0) && (r_den > r_cap[CNT_W-1:0]))
                      ? r_cap[CNT_W-1:0] : r_den;

    // quotient would not fit in 64 bits
    assign sat = (mdu_hi >= r_drun);

    always_comb begin
        mdu_cmd.go = (r_state == S_CLIP) || ((r_state == S_SAT) && !sat);
        mdu_cmd.op = (r_state == S_CLIP) ? MDU_MUL : MDU_DIV;
        mdu_opa    = (r_state == S_CLIP) ? r_dcnt : r_drun;
    end

    mcds_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mdu_cmd),
        .i_opa   (mdu_opa),
        .i_opb   (den_clip),
        .o_stat  (mdu_stat),
        .o_hi    (mdu_hi),
        .o_lo    (mdu_lo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= CFG_RESET;
            r_out_valid <= 1'b0;
            r_skip      <= 1'b0;
            for (int i = 0; i < COUNTER_SLOTS; i++) begin
                r_last_cnt[i] <= '0;
                r_last_en[i]  <= '0;
                r_last_run[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            // in S_DONE the output register is handled below
            if (r_out_valid && i_m_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_slot <= i_s_tdata[SLOT_W-1:0];
                        r_cnt  <= i_s_tdata[SLOT_W +: CNT_W];
                        r_en   <= i_s_tdata[SLOT_W + CNT_W +: CNT_W];
                        r_run  <= i_s_tdata[SLOT_W + 2 * CNT_W +: CNT_W];
                        r_skip <= i_s_tuser || !slot_ok;
                        r_res  <= '0;
                        // failed read: result zero, history untouched
                        r_state <= (i_s_tuser || !slot_ok) ? S_DONE : S_DCNT;
                    end
                end
                S_DCNT: begin
                    r_dcnt  <= sub_y;
                    r_state <= S_DEN;
                end
                S_DEN: begin
                    r_den   <= sub_y;
                    r_state <= S_DRUN;
                end
                S_DRUN: begin
                    r_drun             <= sub_y;
                    r_last_cnt[r_slot] <= r_cnt;
                    r_last_en[r_slot]  <= r_en;
                    r_last_run[r_slot] <= r_run;
                    r_state            <= S_CHK;
                end
                S_CHK: begin
                    // scale only when running advanced but less than enabled
                    if ((r_drun != '0) && (r_den > r_drun)) begin
                        r_state <= S_CAP;
                    end else begin
                        r_res   <= r_dcnt;
                        r_state <= S_DONE;
                    end
                end
                S_CAP: begin
                    r_cap   <= CAP_W'(r_drun) * CAP_W'(factor);
                    r_state <= S_CLIP;
                end
                S_CLIP: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (mdu_stat.done) begin
                        r_state <= S_SAT;
                    end
                end
                S_SAT: begin
                    if (sat) begin
                        r_res   <= '1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (mdu_stat.done) begin
                        r_res   <= mdu_lo;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // wait for room in the output register
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_slot  <= r_slot;
                        r_out_res   <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'({r_out_res, r_out_slot});

    // an accepted reading always takes the sequencer out of idle
    a_acc_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("accepted reading did not start the sequencer");

    // the shared unit only finishes while the sequencer waits on it
    a_mdu_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mdu_stat.done |-> ((r_state == S_MUL) || (r_state == S_DIV)))
        else $error("arithmetic unit finished outside a wait state");

    // a failed read always reports zero
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && r_skip) |-> (r_res == '0))
        else $error("failed read produced a nonzero delta");

    // no new command while the unit is still stepping
    a_mdu_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mdu_stat.busy |-> !mdu_cmd.go)
        else $error("arithmetic unit restarted while busy");

endmodule
